FILE: src/ksc_pkg.sv
// Package: types, constants and codes shared by the keyed slot cache modules.
package ksc_pkg;

  localparam int NUM_SLOTS = 48;
  localparam int DIM_BITS  = 10;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int KEY_W     = 64;
  localparam int TOUCH_W   = 32;
  localparam int SLOT_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  // Input kinds
  localparam logic [2:0] KIND_REQUEST  = 3'd0;
  localparam logic [2:0] KIND_LOOKUP   = 3'd1;
  localparam logic [2:0] KIND_TICK     = 3'd2;
  localparam logic [2:0] KIND_RETARGET = 3'd3;
  localparam logic [2:0] KIND_PICK     = 3'd4;
  localparam logic [2:0] KIND_DONE     = 3'd5;

  // Result status codes
  localparam logic [3:0] RS_REJECTED = 4'd0;
  localparam logic [3:0] RS_TOO_BIG  = 4'd1;
  localparam logic [3:0] RS_HIT      = 4'd2;
  localparam logic [3:0] RS_QUEUED   = 4'd3;
  localparam logic [3:0] RS_NO_SLOT  = 4'd4;
  localparam logic [3:0] RS_LK_HIT   = 4'd5;
  localparam logic [3:0] RS_MISS     = 4'd6;
  localparam logic [3:0] RS_TICKED   = 4'd7;
  localparam logic [3:0] RS_RETARGET = 4'd8;
  localparam logic [3:0] RS_GATED    = 4'd9;
  localparam logic [3:0] RS_NONE_Q   = 4'd10;
  localparam logic [3:0] RS_PICKED   = 4'd11;
  localparam logic [3:0] RS_PUBLISH  = 4'd12;
  localparam logic [3:0] RS_STALE    = 4'd13;
  localparam logic [3:0] RS_FAIL_CLR = 4'd14;

  // Slot states
  localparam logic [1:0] ST_EMPTY  = 2'd0;
  localparam logic [1:0] ST_QUEUED = 2'd1;
  localparam logic [1:0] ST_READY  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PIXELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS       = 2'd3;

  typedef struct packed {
    logic [2:0]          kind;
    logic [KEY_W-1:0]    item_key;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic [SLOT_W-1:0]   slot_index;
    logic                fetch_ok;
  } in_item_t;

  typedef struct packed {
    logic [3:0]          status;
    logic [SLOT_W-1:0]   result_slot;
    logic [KEY_W-1:0]    result_key;
    logic [DIM_BITS-1:0] result_width;
    logic [DIM_BITS-1:0] result_height;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic [1:0]          st;
    logic [TOUCH_W-1:0]  touch;
  } entry_t;

  typedef struct packed {
    logic [19:0] max_pixels;
    logic [15:0] ttl_frames;
    logic [15:0] switch_cooldown;
    logic [15:0] queued_bias;
  } cfg_t;

endpackage

FILE: src/keyed_slot_cache_with_ttl.sv
// Top level: configuration registers, slot memory and sequencer.
//
// Keyed slot cache with time-to-live. Items are handled one at a time. Kinds
// that scan the table (request, lookup, tick, retarget, fetch pick) read all
// NUM_SLOTS entries through the single read port of the slot memory, one per
// cycle; a fetch done reads one entry, and items rejected by their up-front
// checks read none. The next item is accepted as soon as the result sits in
// the output register. Configuration writes are always ready and must only
// be issued while the block is idle.
module keyed_slot_cache_with_ttl import ksc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o
);

  cfg_t             cfg_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_pixels      <= 20'd262144;
      cfg_q.ttl_frames      <= 16'd180;
      cfg_q.switch_cooldown <= 16'd20;
      cfg_q.queued_bias     <= 16'd30;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_PIXELS: cfg_q.max_pixels      <= cfg_data_i;
        CFG_TTL:        cfg_q.ttl_frames      <= cfg_data_i[15:0];
        CFG_COOLDOWN:   cfg_q.switch_cooldown <= cfg_data_i[15:0];
        CFG_BIAS:       cfg_q.queued_bias     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  ksc_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  ksc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // One item in flight: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a second item while busy");

  // Only a pick result carries a key
  a_key_only_on_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != RS_PICKED |-> out_item_o.result_key == '0)
    else $error("key on a non-pick result");

  // Tick and retarget results name no slot
  a_tick_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == RS_TICKED || out_item_o.status == RS_RETARGET)
    |-> out_item_o.result_slot == '0)
    else $error("slot on a tick or retarget result");

endmodule

FILE: src/ksc_mem.sv
// Slot memory: one write and one registered read port, per-entry valid bits.
module ksc_mem import ksc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output entry_t           rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  entry_t           wr_data_i
);

  entry_t                 mem_q [NUM_SLOTS];
  logic   [NUM_SLOTS-1:0] valid_q;
  entry_t                 rd_data_q;
  logic                   rd_valid_q;

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits: an unwritten entry reads as all zero (empty)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

FILE: src/ksc_ctrl.sv
// Sequencer: reads the slot memory for each item that passes its up-front checks, decides and writes back.
module ksc_ctrl import ksc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o,
  output logic             rd_en_o,
  output logic [IDX_W-1:0] rd_addr_o,
  input  entry_t           rd_data_i,
  output logic             wr_en_o,
  output logic [IDX_W-1:0] wr_addr_o,
  output entry_t           wr_data_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  logic [2:0]         state_q, state_d;
  in_item_t           item_q;
  logic [TOUCH_W-1:0] frame_q, frame_d;
  logic [TOUCH_W-1:0] hold_q, hold_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic               iss_q, iss_d;
  logic               r_vld_q;
  logic [IDX_W-1:0]   r_idx_q;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   found_idx_q, found_idx_d;
  entry_t             ent_q, ent_d;
  logic               emp_q, emp_d;
  logic [IDX_W-1:0]   emp_idx_q, emp_idx_d;
  logic               best_q, best_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [TOUCH_W-1:0] best_val_q, best_val_d;
  logic [TOUCH_W-1:0] best_raw_q, best_raw_d;
  out_item_t          res_q, res_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic [IDX_W-1:0]   last_idx;
  logic               si_ok;
  logic [IDX_W-1:0]   si_idx;
  logic               dims_match;
  logic [TOUCH_W-1:0] raw_age, age, pick_d, hold_diff;
  logic [31:0]        pix;
  logic               key_match;

  assign si_ok      = 32'(item_q.slot_index) < NUM_SLOTS;
  assign si_idx     = IDX_W'(item_q.slot_index);
  assign last_idx   = (item_q.kind == KIND_DONE) ? si_idx : LAST_IDX;
  assign dims_match = (rd_data_i.width == item_q.width) && (rd_data_i.height == item_q.height)
                      && (rd_data_i.key == item_q.item_key);
  assign raw_age    = frame_q - rd_data_i.touch;
  assign age        = (raw_age > 32'(cfg_i.queued_bias)) ? raw_age - 32'(cfg_i.queued_bias)
                                                         : '0;
  assign pick_d     = rd_data_i.touch - best_val_q;
  assign hold_diff  = hold_q - frame_q;
  assign pix        = 32'(item_q.width) * 32'(item_q.height);
  assign key_match  = (item_q.item_key != '0) && (ent_q.key == item_q.item_key);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    frame_d     = frame_q;
    hold_d      = hold_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    ent_d       = ent_q;
    emp_d       = emp_q;
    emp_idx_d   = emp_idx_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    best_val_d  = best_val_q;
    best_raw_d  = best_raw_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = cnt_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = r_idx_q;
    wr_data_o   = rd_data_i;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.kind == KIND_TICK) begin
            frame_d = frame_q + 1'b1;
          end
          state_d = S_START;
        end
      end

      // Up-front checks; start the scan where one is needed
      S_START: begin
        res_d       = '0;
        found_d     = 1'b0;
        emp_d       = 1'b0;
        best_d      = 1'b0;
        best_val_d  = '0;
        cnt_d       = '0;
        iss_d       = 1'b1;
        state_d     = S_SCAN;
        case (item_q.kind)
          KIND_REQUEST: begin
            if (item_q.item_key == '0 || item_q.width == '0 || item_q.height == '0) begin
              res_d.status = RS_REJECTED;
              state_d      = S_OUT;
            end else if (pix > 32'(cfg_i.max_pixels)) begin
              res_d.status = RS_TOO_BIG;
              state_d      = S_OUT;
            end
          end
          KIND_LOOKUP: begin
            if (item_q.item_key == '0) begin
              res_d.status = RS_REJECTED;
              state_d      = S_OUT;
            end
          end
          KIND_TICK: ;
          KIND_RETARGET: begin
            hold_d = frame_q + 32'(cfg_i.switch_cooldown);
          end
          KIND_PICK: begin
            if (hold_diff != '0 && !hold_diff[TOUCH_W-1]) begin
              res_d.status = RS_GATED;
              state_d      = S_OUT;
            end
          end
          KIND_DONE: begin
            cnt_d = si_idx;
            if (!si_ok) begin
              res_d.status      = RS_STALE;
              res_d.result_slot = item_q.slot_index;
              state_d           = S_OUT;
            end
          end
          default: begin
            res_d.status = RS_REJECTED;
            state_d      = S_OUT;
          end
        endcase
      end

      // Issue reads; handle each entry in the cycle after its read is issued
      S_SCAN: begin
        if (iss_q) begin
          rd_en_o = 1'b1;
          if (cnt_q == last_idx) begin
            iss_d = 1'b0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (r_vld_q) begin
          case (item_q.kind)
            KIND_REQUEST: begin
              if (rd_data_i.st != ST_EMPTY && dims_match && !found_q) begin
                found_d     = 1'b1;
                found_idx_d = r_idx_q;
                ent_d       = rd_data_i;
              end
              if (!emp_q) begin
                if (rd_data_i.st == ST_EMPTY) begin
                  emp_d     = 1'b1;
                  emp_idx_d = r_idx_q;
                end else begin
                  if (!best_q || (((rd_data_i.st == ST_QUEUED) ? age : raw_age) > best_val_q))
                  begin
                    best_d     = 1'b1;
                    best_idx_d = r_idx_q;
                    best_val_d = (rd_data_i.st == ST_QUEUED) ? age : raw_age;
                    best_raw_d = raw_age;
                  end
                end
              end
            end
            KIND_LOOKUP: begin
              if (rd_data_i.st == ST_READY && dims_match && !found_q) begin
                found_d     = 1'b1;
                found_idx_d = r_idx_q;
                ent_d       = rd_data_i;
              end
            end
            KIND_TICK: begin
              if (rd_data_i.st != ST_EMPTY && raw_age > 32'(cfg_i.ttl_frames)) begin
                wr_en_o      = 1'b1;
                wr_data_o.st  = ST_EMPTY;
                wr_data_o.key = '0;
              end
            end
            KIND_RETARGET: begin
              if (rd_data_i.st != ST_EMPTY) begin
                wr_en_o         = 1'b1;
                wr_data_o.touch = frame_q - 32'(cfg_i.ttl_frames);
              end
            end
            KIND_PICK: begin
              if (rd_data_i.st == ST_QUEUED &&
                  (!best_q || (pick_d != '0 && !pick_d[TOUCH_W-1]))) begin
                best_d     = 1'b1;
                best_idx_d = r_idx_q;
                best_val_d = rd_data_i.touch;
                ent_d      = rd_data_i;
              end
            end
            default: begin
              ent_d = rd_data_i;
            end
          endcase
          if (r_idx_q == last_idx) begin
            state_d = S_FINAL;
          end
        end
      end

      // Decide the result and, for request, lookup and fetch done, write the chosen entry back
      S_FINAL: begin
        state_d   = S_OUT;
        wr_data_o = ent_q;
        case (item_q.kind)
          KIND_REQUEST: begin
            if (found_q) begin
              wr_en_o           = 1'b1;
              wr_addr_o         = found_idx_q;
              wr_data_o.touch   = frame_q;
              res_d.status      = RS_HIT;
              res_d.result_slot = SLOT_W'(found_idx_q);
            end else if (emp_q || (best_q && best_raw_q != '0)) begin
              wr_en_o           = 1'b1;
              wr_addr_o         = emp_q ? emp_idx_q : best_idx_q;
              wr_data_o.key     = item_q.item_key;
              wr_data_o.width   = item_q.width;
              wr_data_o.height  = item_q.height;
              wr_data_o.st      = ST_QUEUED;
              wr_data_o.touch   = frame_q;
              res_d.status      = RS_QUEUED;
              res_d.result_slot = SLOT_W'(emp_q ? emp_idx_q : best_idx_q);
            end else begin
              res_d.status = RS_NO_SLOT;
            end
          end
          KIND_LOOKUP: begin
            if (found_q) begin
              wr_en_o           = 1'b1;
              wr_addr_o         = found_idx_q;
              wr_data_o.touch   = frame_q;
              res_d.status      = RS_LK_HIT;
              res_d.result_slot = SLOT_W'(found_idx_q);
            end else begin
              res_d.status = RS_MISS;
            end
          end
          KIND_TICK:     res_d.status = RS_TICKED;
          KIND_RETARGET: res_d.status = RS_RETARGET;
          KIND_PICK: begin
            if (best_q) begin
              res_d.status        = RS_PICKED;
              res_d.result_slot   = SLOT_W'(best_idx_q);
              res_d.result_key    = ent_q.key;
              res_d.result_width  = ent_q.width;
              res_d.result_height = ent_q.height;
            end else begin
              res_d.status = RS_NONE_Q;
            end
          end
          default: begin
            // fetch done
            res_d.result_slot = item_q.slot_index;
            wr_addr_o         = si_idx;
            res_d.status      = RS_STALE;
            if (item_q.fetch_ok) begin
              if (key_match && ent_q.st == ST_QUEUED) begin
                wr_en_o      = 1'b1;
                wr_data_o.st = ST_READY;
                res_d.status = RS_PUBLISH;
              end
            end else if (key_match) begin
              wr_en_o      = 1'b1;
              wr_data_o.st = ST_EMPTY;
              res_d.status = RS_FAIL_CLR;
            end
          end
        endcase
      end

      // Hand the result to the output register
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      frame_q     <= '0;
      hold_q      <= '0;
      iss_q       <= 1'b0;
      r_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_q     <= frame_d;
      hold_q      <= hold_d;
      iss_q       <= iss_d;
      r_vld_q     <= rd_en_o;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and scratch registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      item_q <= in_item_i;
    end
    r_idx_q     <= cnt_q;
    cnt_q       <= cnt_d;
    found_q     <= found_d;
    found_idx_q <= found_idx_d;
    ent_q       <= ent_d;
    emp_q       <= emp_d;
    emp_idx_q   <= emp_idx_d;
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    best_val_q  <= best_val_d;
    best_raw_q  <= best_raw_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

endmodule
